### src/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
package mexp_pkg;

  // Field widths.
  localparam int MOD_W    = 31;
  localparam int BASE_W   = 63;
  localparam int EXP_W    = 63;
  localparam int EXP_BITS = 63;
  localparam int DIV_W    = 64;

  // Stream data widths, padded to whole bytes.
  localparam int S_DATA_W = 128;
  localparam int M_DATA_W = 32;

  // Modulus after reset.
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

  // Request to the shared reduction unit.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } mexp_red_req_t;

  // Response from the shared reduction unit.
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem;
  } mexp_red_rsp_t;

endpackage

### src/mexp_redc.sv
// Iterative reduction unit: 64-bit dividend modulo a 31-bit modulus, two bits per cycle.
module mexp_redc
  import mexp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [MOD_W-1:0] modulus,
  input  mexp_red_req_t    req,
  output mexp_red_rsp_t    rsp
);

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [MOD_W-1:0] rem;
  logic             done;

  logic [MOD_W:0]   t1;
  logic [MOD_W:0]   t2;
  logic [MOD_W-1:0] r1;
  logic [MOD_W-1:0] rem_next;

  // Two restoring remainder steps, one for each of the next two dividend bits.
  always_comb begin
    t1 = {rem, dvd[DIV_W-1]};
    if (t1 >= {1'b0, modulus}) begin
      t1 = t1 - {1'b0, modulus};
    end
    r1 = t1[MOD_W-1:0];
    t2 = {r1, dvd[DIV_W-2]};
    if (t2 >= {1'b0, modulus}) begin
      t2 = t2 - {1'b0, modulus};
    end
    rem_next = t2[MOD_W-1:0];
  end

  // Step counter and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shift register and partial remainder.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-3:0], 2'b00};
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

  // The sequencer never restarts the unit while it is working.
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("reduction started while busy");

  // A finished remainder is always below a nonzero modulus.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (done && modulus != '0) |-> rem < modulus)
    else $error("remainder not reduced");

  // Completion follows a busy cycle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without work");

endmodule

### src/modular_exponentiation.sv
// Top level: square-and-multiply sequencer around a shared multiplier and reduction unit.
//
// Usage:
// - s_tdata carries one request: base and exponent. The block takes it when
//   s_tvalid and s_tready are both high; s_tready is high only while idle.
// - m_tdata returns base to the exponent modulo the modulus, one result per request.
// - cfg_we with cfg_wdata writes the modulus; write it only while idle.
// Operation: the base is reduced first. Then each exponent bit up to the
// highest set one costs a square and, where the bit is set, a multiply;
// the square after the last set bit is skipped. Every multiply goes
// through the reduction unit (two remainder bits per cycle). Exponent zero
// or a zero modulus skip the loop: the sequencer goes to its step state
// and from there the valid result moves into the output register.
// The next request is taken once the result has moved into the output register.
// A stalled receiver holds the result in that register; the block then waits
// with its finished result before returning to idle.
// Reset clears all handshakes and sets the modulus to 1000000007.
module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [MOD_W-1:0]    cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [62:0] base, [125:63] exponent, [127:126] zero
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // [30:0] result, [31] zero
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STEP = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;

  localparam logic [1:0] PH_BASE = 2'd0;
  localparam logic [1:0] PH_ACC  = 2'd1;
  localparam logic [1:0] PH_SQ   = 2'd2;

  logic [2:0]          state;
  logic [1:0]          phase;
  logic [MOD_W-1:0]    modulus;
  logic [EXP_BITS-1:0] e;
  logic [MOD_W-1:0]    acc;
  logic [MOD_W-1:0]    sq;
  logic [DIV_W-1:0]    prod;
  logic [MOD_W-1:0]    res;

  logic                accept;
  logic                out_free;
  logic                res_load;
  logic [BASE_W-1:0]   in_base;
  logic [EXP_BITS-1:0] in_exp;
  logic [MOD_W-1:0]    mul_a;
  logic [2*MOD_W-1:0]  mul_p;

  mexp_red_req_t       red_req;
  mexp_red_rsp_t       red_rsp;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_base  = s_tdata[BASE_W-1:0];
  assign in_exp   = s_tdata[BASE_W +: EXP_BITS];

  // The finished result moves into the output register once it is free.
  assign res_load = (state == ST_STEP) && (e == '0) && out_free;

  // Shared multiplier: acc times sq in a multiply step, sq times sq otherwise.
  assign mul_a = (state == ST_STEP && e[0]) ? acc : sq;
  assign mul_p = mul_a * sq;

  assign red_req.start    = (state == ST_MUL);
  assign red_req.dividend = prod;

  mexp_redc u_redc (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (red_req),
    .rsp     (red_rsp)
  );

  // Modulus register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  // Sequencer state and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_exp == '0 || modulus == '0) begin
              state <= ST_STEP;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_STEP: begin
          if (e == '0) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_MUL;
          end
        end
        ST_SQ:   state <= ST_MUL;
        ST_MUL:  state <= ST_WAIT;
        ST_WAIT: begin
          if (red_rsp.done) begin
            if (phase == PH_ACC && (e >> 1) != '0) begin
              state <= ST_SQ;
            end else begin
              state <= ST_STEP;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          prod  <= DIV_W'(in_base);
          phase <= PH_BASE;
          if (in_exp == '0) begin
            acc <= MOD_W'(1);
            e   <= '0;
          end else if (modulus == '0) begin
            acc <= '0;
            e   <= '0;
          end else begin
            e <= in_exp;
          end
        end
      end
      ST_STEP: begin
        if (e == '0) begin
          if (out_free) begin
            res <= acc;
          end
        end else begin
          prod  <= DIV_W'(mul_p);
          phase <= e[0] ? PH_ACC : PH_SQ;
        end
      end
      ST_SQ: begin
        prod  <= DIV_W'(mul_p);
        phase <= PH_SQ;
      end
      ST_WAIT: begin
        if (red_rsp.done) begin
          case (phase)
            PH_BASE: begin
              sq  <= red_rsp.rem;
              acc <= (modulus == MOD_W'(1)) ? '0 : MOD_W'(1);
            end
            PH_ACC: begin
              acc <= red_rsp.rem;
              if ((e >> 1) == '0) begin
                e <= '0;
              end
            end
            PH_SQ: begin
              sq <= red_rsp.rem;
              e  <= e >> 1;
            end
            default: begin
              sq <= red_rsp.rem;
            end
          endcase
        end
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

  assign m_tdata = {{(M_DATA_W - MOD_W){1'b0}}, res};

  // An accepted request always leaves idle.
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  // The reduction unit only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    red_rsp.done |-> state == ST_WAIT)
    else $error("reduction finished outside wait");

  // Running values stay reduced once the loop is active.
  a_operands_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ && modulus != '0) |-> (acc < modulus && sq < modulus))
    else $error("operand not reduced");

  // The reduction unit is started only from the multiply issue state.
  a_start_once: assert property (@(posedge clk) disable iff (rst)
    red_req.start |=> state == ST_WAIT)
    else $error("reduction start not followed by wait");

endmodule
